[design/event_count_record_batcher_macros.svh]
// Assertion macros shared by the checker of the event count record batcher.
// Holds macro definitions only; no other dependencies.
`ifndef EVENT_COUNT_RECORD_BATCHER_MACROS_SVH
`define EVENT_COUNT_RECORD_BATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ecrb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ECRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ecrb assertion failed");

`endif

[design/ecrb_pkg.sv]
// Package of the event count record batcher: request and result types,
// command, kind and register codes, and sizing constants. No dependencies.
package ecrb_pkg;

	localparam int RECORDS_PER_PACKET = 32;
	localparam int CODE_TABLE_DEPTH = 255;

	localparam int CODE_AW = $clog2(CODE_TABLE_DEPTH);
	localparam int PEND_W = $clog2(RECORDS_PER_PACKET + 1);
	localparam logic [8:0] CODE_LIMIT = 9'(CODE_TABLE_DEPTH);

	localparam int SLOT_W = 5;
	localparam int TOTAL_W = 6;

	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_FIFO_AW = $clog2(RES_FIFO_DEPTH);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [31:0] PAUSE_RESET = 32'd10000;
	localparam logic [31:0] KEEPALIVE_RESET = 32'd5000000;
	localparam logic [31:0] TIMEOUT_RESET = 32'd50;

	localparam logic [1:0] CMD_EVENT = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_SUBSCRIBE = 2'd2;

	localparam logic [1:0] REG_PAUSE = 2'd0;
	localparam logic [1:0] REG_KEEPALIVE = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	typedef enum logic [2:0] {
		K_RECORD = 3'd0,
		K_FULL = 3'd1,
		K_PARTIAL = 3'd2,
		K_KEEPALIVE = 3'd3,
		K_EXPIRED = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] event_code;
		logic [31:0] event_seconds;
		logic [31:0] event_ticks;
		logic [31:0] now_microseconds;
		logic [31:0] now_seconds;
		logic [31:0] subscribe_nonce;
	} req_t;

	typedef struct packed {
		kind_t kind;
		logic [SLOT_W-1:0] record_slot;
		logic [7:0] out_code;
		logic [31:0] out_seconds;
		logic [31:0] out_ticks;
		logic [31:0] out_count;
		logic [31:0] sequence_res;
		logic [TOTAL_W-1:0] record_total;
		logic last;
	} rsp_t;

endpackage

[design/ecrb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
module ecrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ecrb_res_fifo.sv]
// Result queue of the batcher: takes up to two results a cycle and hands
// them out one at a time. Depends on ecrb_pkg.
module ecrb_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    wr_cnt,
	input  ecrb_pkg::rsp_t wr_data0,
	input  ecrb_pkg::rsp_t wr_data1,
	output logic          room2,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ecrb_pkg::rsp_t rsp
);
	import ecrb_pkg::*;

	rsp_t                   buf_q [RES_FIFO_DEPTH];
	logic [RES_FIFO_AW-1:0] wp_q;
	logic [RES_FIFO_AW-1:0] rp_q;
	logic [RES_FIFO_AW:0]   cnt_q;
	logic                   pop;
	logic [RES_FIFO_AW-1:0] wp_next;

	assign pop = rsp_valid && rsp_ready;
	assign wp_next = wp_q + RES_FIFO_AW'(1);
	assign rsp_valid = (cnt_q != '0);
	assign rsp = buf_q[rp_q];
	assign room2 = (cnt_q <= (RES_FIFO_AW+1)'(RES_FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			buf_q[wp_q] <= wr_data0;
		end
		if (wr_cnt == 2'd2) begin
			buf_q[wp_next] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + RES_FIFO_AW'(wr_cnt);
			if (pop) begin
				rp_q <= rp_q + RES_FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (RES_FIFO_AW+1)'(wr_cnt) - (RES_FIFO_AW+1)'(pop);
		end
	end

endmodule

[design/event_count_record_batcher.sv]
// Top level of the event count record batcher: request stage, counter RAM
// with forwarding, packet state and APB registers. Uses ecrb_pkg, ecrb_ram
// and ecrb_res_fifo.
//
//   Channel   Signals                              Direction  Content
//   req       req_valid, req_ready, req            in         one request (req_t)
//   rsp       rsp_valid, rsp_ready, rsp            out        one result (rsp_t)
//   apb       psel, penable, pwrite, paddr, ...    in/out     three 32-bit registers
//
// A request is registered into the request stage at acceptance, and its results
// enter the result queue when the stage retires it; rsp is offered from the queue.
// One request per cycle is sustained while the result queue has room for two
// results; a request with two results offers them on rsp one at a time.
// Reset clears the per-code valid bits at once, so no clearing pass is needed.
// A stalled rsp backs up the four-entry result queue, which then stalls req.
module event_count_record_batcher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ecrb_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ecrb_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ecrb_pkg::PADDR_W-1:0]  paddr,
	input  logic [ecrb_pkg::PDATA_W-1:0]  pwdata,
	output logic [ecrb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ecrb_pkg::*;

	// Configuration registers.
	logic [31:0] pause_q;
	logic [31:0] keepalive_q;
	logic [31:0] timeout_q;
	logic [1:0]  reg_idx;
	logic        reg_wr;

	// Request stage: the counter RAM read was issued at acceptance, so its
	// data lines up with the request held here.
	logic req_vld_s1;
	req_t req_s1;

	// Packet and subscription state.
	logic              subscribed_q;
	logic [31:0]       sub_time_q;
	logic [31:0]       last_nonce_q;
	logic [PEND_W-1:0] pending_q;
	logic [31:0]       first_time_q;
	logic [31:0]       last_send_q;
	logic [31:0]       pkt_seq_q;

	// Counter table: one valid bit per code, plus the most recent write kept
	// for forwarding to a request whose read overlapped that write.
	logic [CODE_TABLE_DEPTH-1:0] cnt_vld_q;
	logic                        wr_vld_q;
	logic [CODE_AW-1:0]          wr_addr_q;
	logic [31:0]                 wr_cnt_q;
	logic [31:0]                 ram_rdata;

	logic room2;
	logic fire;
	logic accept;

	logic              is_evt;
	logic              is_tick;
	logic              is_sub;
	logic              active;
	logic              expired;
	logic              code_ok;
	logic [CODE_AW-1:0] code_addr;
	logic [31:0]       cnt_base;
	logic [31:0]       cnt_new;
	logic [PEND_W-1:0] pend_inc;
	logic              full;
	logic              partial;
	logic              keep;
	logic              do_record;
	logic              do_tick;
	logic              ram_we;
	logic [31:0]       seq_one;
	logic [31:0]       seq_two;
	logic [31:0]       since_send;

	rsp_t       res0;
	rsp_t       res1;
	logic [1:0] res_cnt;

	// APB: writes complete in the access phase, never with wait states.
	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_PAUSE:     prdata = pause_q;
			REG_KEEPALIVE: prdata = keepalive_q;
			REG_TIMEOUT:   prdata = timeout_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_q <= PAUSE_RESET;
			keepalive_q <= KEEPALIVE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_PAUSE:     pause_q <= pwdata;
				REG_KEEPALIVE: keepalive_q <= pwdata;
				REG_TIMEOUT:   timeout_q <= pwdata;
				default:       ;
			endcase
		end
	end

	// The stage retires its request only when the result queue can take two
	// results, so nothing is ever dropped; a new request enters as it leaves.
	assign fire = req_vld_s1 && room2;
	assign req_ready = !req_vld_s1 || room2;
	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (accept) begin
			req_vld_s1 <= 1'b1;
		end else if (fire) begin
			req_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// The RAM only reads on acceptance, so its output holds while the stage
	// waits on a full result queue.
	ecrb_ram #(
		.WIDTH(32),
		.DEPTH(CODE_TABLE_DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(code_addr),
		.wdata(cnt_new),
		.re   (accept),
		.raddr(req.event_code[CODE_AW-1:0]),
		.rdata(ram_rdata)
	);

	// Decode of the request in the stage.
	assign is_evt = (req_s1.command == CMD_EVENT);
	assign is_tick = (req_s1.command == CMD_TICK);
	assign is_sub = (req_s1.command == CMD_SUBSCRIBE);
	assign active = subscribed_q && (is_evt || is_tick);
	assign expired = (req_s1.now_seconds - sub_time_q) > timeout_q;
	assign code_addr = req_s1.event_code[CODE_AW-1:0];
	assign code_ok = (req_s1.event_code != 8'd0) &&
		(9'(req_s1.event_code) < CODE_LIMIT);

	// A code never written reads as zero. When the previous retired request
	// wrote this code in the same cycle as this read, the RAM returned the
	// old value, so the kept write takes precedence.
	always_comb begin
		priority if (wr_vld_q && (wr_addr_q == code_addr)) begin
			cnt_base = wr_cnt_q;
		end else if (code_ok && cnt_vld_q[code_addr]) begin
			cnt_base = ram_rdata;
		end else begin
			cnt_base = '0;
		end
	end
	assign cnt_new = cnt_base + 32'd1;

	assign do_record = active && !expired && is_evt && code_ok;
	assign do_tick = active && !expired && is_tick;
	assign ram_we = fire && do_record;

	assign pend_inc = pending_q + PEND_W'(1);
	assign full = (pend_inc >= PEND_W'(RECORDS_PER_PACKET));

	// A partial close counts as a send, which leaves zero time since it.
	assign partial = (pending_q != '0) &&
		((req_s1.now_microseconds - first_time_q) > pause_q);
	assign since_send = partial ? 32'd0 : (req_s1.now_microseconds - last_send_q);
	assign keep = (since_send >= keepalive_q);

	assign seq_one = pkt_seq_q + 32'd1;
	assign seq_two = pkt_seq_q + 32'd2;

	// Result assembly. Fields that do not apply to a kind stay zero.
	always_comb begin
		res0 = '0;
		res1 = '0;
		res_cnt = 2'd0;
		priority if (!fire || !active) begin
			res_cnt = 2'd0;
		end else if (expired) begin
			res0.kind = K_EXPIRED;
			res0.last = 1'b1;
			res_cnt = 2'd1;
		end else if (do_record) begin
			res0.kind = K_RECORD;
			res0.record_slot = SLOT_W'(pending_q);
			res0.out_code = req_s1.event_code;
			res0.out_seconds = req_s1.event_seconds;
			res0.out_ticks = req_s1.event_ticks;
			res0.out_count = cnt_new;
			res0.sequence_res = seq_one;
			if (full) begin
				res1.kind = K_FULL;
				res1.sequence_res = seq_one;
				res1.record_total = TOTAL_W'(pend_inc);
				res1.last = 1'b1;
				res_cnt = 2'd2;
			end else begin
				res0.last = 1'b1;
				res_cnt = 2'd1;
			end
		end else if (do_tick) begin
			if (partial) begin
				res0.kind = K_PARTIAL;
				res0.sequence_res = seq_one;
				res0.record_total = TOTAL_W'(pending_q);
				if (keep) begin
					res1.kind = K_KEEPALIVE;
					res1.sequence_res = seq_two;
					res1.last = 1'b1;
					res_cnt = 2'd2;
				end else begin
					res0.last = 1'b1;
					res_cnt = 2'd1;
				end
			end else if (keep) begin
				res0.kind = K_KEEPALIVE;
				res0.sequence_res = seq_one;
				res0.last = 1'b1;
				res_cnt = 2'd1;
			end
		end
	end

	// State update when the request retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subscribed_q <= 1'b0;
			sub_time_q <= '0;
			last_nonce_q <= '0;
			pending_q <= '0;
			first_time_q <= '0;
			last_send_q <= '0;
			pkt_seq_q <= '0;
		end else if (fire) begin
			if (is_sub) begin
				subscribed_q <= 1'b1;
				sub_time_q <= req_s1.now_seconds;
				if (req_s1.subscribe_nonce != last_nonce_q) begin
					last_nonce_q <= req_s1.subscribe_nonce;
					pending_q <= '0;
				end
			end else if (active && expired) begin
				subscribed_q <= 1'b0;
			end else if (active && is_evt) begin
				// Even an uncounted code opens the pause window.
				if (pending_q == '0) begin
					first_time_q <= req_s1.now_microseconds;
				end
				if (code_ok) begin
					if (full) begin
						pending_q <= '0;
						pkt_seq_q <= seq_one;
						last_send_q <= req_s1.now_microseconds;
					end else begin
						pending_q <= pend_inc;
					end
				end
			end else if (do_tick) begin
				if (partial) begin
					pending_q <= '0;
				end
				if (partial || keep) begin
					last_send_q <= req_s1.now_microseconds;
				end
				pkt_seq_q <= pkt_seq_q + 32'(partial) + 32'(keep);
			end
		end
	end

	// Counter table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			wr_vld_q <= 1'b0;
		end else if (ram_we) begin
			cnt_vld_q[code_addr] <= 1'b1;
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_addr_q <= code_addr;
			wr_cnt_q <= cnt_new;
		end
	end

	ecrb_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (res_cnt),
		.wr_data0 (res0),
		.wr_data1 (res1),
		.room2    (room2),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

[design/ecrb_checker.sv]
// Port-level checker of the event count record batcher, bound to the top level.
// Depends on ecrb_pkg and event_count_record_batcher_macros.svh.
`include "event_count_record_batcher_macros.svh"

module ecrb_port_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ecrb_pkg::rsp_t rsp
);
	import ecrb_pkg::*;

	// A stalled result holds.
	`ECRB_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// An expiry carries nothing but its kind and the final flag.
	`ECRB_ASSERT_IMP(a_expired_empty, clk, arst_n, rsp_valid && (rsp.kind == K_EXPIRED), (rsp.record_slot == '0) && (rsp.out_count == '0) && (rsp.sequence_res == '0) && (rsp.record_total == '0) && rsp.last)

	// A keepalive is empty and always ends its request's results.
	`ECRB_ASSERT_IMP(a_keepalive_empty, clk, arst_n, rsp_valid && (rsp.kind == K_KEEPALIVE), (rsp.record_total == '0) && rsp.last)

	// A record that is not final is followed at once by the full close of the
	// same packet.
	`ECRB_ASSERT_NXT(a_record_then_full, clk, arst_n, rsp_valid && rsp_ready && (rsp.kind == K_RECORD) && !rsp.last, rsp_valid && (rsp.kind == K_FULL) && (rsp.sequence_res == $past(rsp.sequence_res)))

endmodule

bind event_count_record_batcher ecrb_port_checker u_ecrb_checker (.*);

[dv/ecrb_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the event count record batcher: watches the request, result
// and register channels, predicts every result and compares it field by field.
// Depends on ecrb_pkg only.
module ecrb_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  ecrb_pkg::req_t               req,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  ecrb_pkg::rsp_t               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [ecrb_pkg::PADDR_W-1:0] paddr,
	input  logic [ecrb_pkg::PDATA_W-1:0] pwdata,
	output int                           error_count,
	output int                           pending_results,
	output int                           records_seen,
	output int                           packets_seen,
	output int                           expiries_seen
);
	import ecrb_pkg::*;

	logic [31:0] pause_us;
	logic [31:0] keepalive_us;
	logic [31:0] timeout_s;

	logic [31:0] code_counts [1:CODE_TABLE_DEPTH-1];
	logic        live;
	logic [31:0] subscribed_at;
	logic [31:0] nonce_held;
	logic [31:0] first_arrival;
	logic [31:0] last_send;
	logic [31:0] sequence_no;
	int unsigned records_held;

	rsp_t expected_results [$];

	// Sends a packet: bumps the sequence number and stamps the send time.
	function automatic rsp_t close_packet(input kind_t k, input logic [31:0] now);
		rsp_t p;
		p = '0;
		sequence_no = sequence_no + 32'd1;
		p.kind = k;
		p.sequence_res = sequence_no;
		if (k != K_KEEPALIVE) begin
			p.record_total = TOTAL_W'(records_held);
			records_held = 0;
		end
		last_send = now;
		return p;
	endfunction

	task automatic predict_results(input req_t r);
		rsp_t batch [$];
		rsp_t rec;
		logic [31:0] count_next;
		if (r.command == CMD_SUBSCRIBE) begin
			live = 1'b1;
			subscribed_at = r.now_seconds;
			if (r.subscribe_nonce != nonce_held) begin
				nonce_held = r.subscribe_nonce;
				records_held = 0;
			end
		end else if (live && (r.command == CMD_EVENT || r.command == CMD_TICK)) begin
			if (32'(r.now_seconds - subscribed_at) > timeout_s) begin
				live = 1'b0;
				rec = '0;
				rec.kind = K_EXPIRED;
				batch.push_back(rec);
			end else if (r.command == CMD_EVENT) begin
				if (records_held == 0)
					first_arrival = r.now_microseconds;
				if (r.event_code >= 8'd1 && r.event_code < CODE_LIMIT) begin
					count_next = code_counts[r.event_code] + 32'd1;
					code_counts[r.event_code] = count_next;
					rec = '0;
					rec.kind = K_RECORD;
					rec.record_slot = SLOT_W'(records_held);
					rec.out_code = r.event_code;
					rec.out_seconds = r.event_seconds;
					rec.out_ticks = r.event_ticks;
					rec.out_count = count_next;
					rec.sequence_res = sequence_no + 32'd1;
					batch.push_back(rec);
					records_held++;
					if (records_held >= RECORDS_PER_PACKET)
						batch.push_back(close_packet(K_FULL, r.now_microseconds));
				end
			end else begin
				if (records_held != 0 &&
						32'(r.now_microseconds - first_arrival) > pause_us)
					batch.push_back(close_packet(K_PARTIAL, r.now_microseconds));
				if (32'(r.now_microseconds - last_send) >= keepalive_us)
					batch.push_back(close_packet(K_KEEPALIVE, r.now_microseconds));
			end
		end
		if (batch.size() > 0) begin
			rec = batch.pop_back();
			rec.last = 1'b1;
			batch.push_back(rec);
			foreach (batch[i])
				expected_results.push_back(batch[i]);
		end
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (expected_results.size() == 0) begin
			$error("result of kind %0d arrived with nothing expected", got.kind);
			error_count++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("kind", 32'(want.kind), 32'(got.kind));
		compare_field("record_slot", 32'(want.record_slot), 32'(got.record_slot));
		compare_field("out_code", 32'(want.out_code), 32'(got.out_code));
		compare_field("out_seconds", want.out_seconds, got.out_seconds);
		compare_field("out_ticks", want.out_ticks, got.out_ticks);
		compare_field("out_count", want.out_count, got.out_count);
		compare_field("sequence_res", want.sequence_res, got.sequence_res);
		compare_field("record_total", 32'(want.record_total), 32'(got.record_total));
		compare_field("last", 32'(want.last), 32'(got.last));
		case (want.kind)
			K_RECORD: records_seen++;
			K_EXPIRED: expiries_seen++;
			default: packets_seen++;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_us = PAUSE_RESET;
			keepalive_us = KEEPALIVE_RESET;
			timeout_s = TIMEOUT_RESET;
			for (int i = 1; i < CODE_TABLE_DEPTH; i++)
				code_counts[i] = '0;
			live = 1'b0;
			subscribed_at = '0;
			nonce_held = '0;
			first_arrival = '0;
			last_send = '0;
			sequence_no = '0;
			records_held = 0;
			expected_results.delete();
		end else begin
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (req_valid && req_ready)
				predict_results(req);
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PAUSE: pause_us = pwdata;
					REG_KEEPALIVE: keepalive_us = pwdata;
					REG_TIMEOUT: timeout_s = pwdata;
					default: ;
				endcase
			end
		end
		pending_results = expected_results.size();
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the event count record batcher testbench: clock, reset, request and
// register stimulus, result-side backpressure, watchdog and the verdict.
// Depends on ecrb_pkg, ecrb_checker and the event_count_record_batcher RTL.
module testbench;
	import ecrb_pkg::*;

	// The package names no code for the fourth command value; the block must
	// ignore it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Length of the long result-side hold-off that fills the result queue.
	localparam int HOLD_CYCLES = 300;
	// Cycles with no handshake of any kind before the run is declared hung.
	// The longest legal quiet stretch is the hold-off above plus a sender gap.
	localparam int QUIET_LIMIT = 4000;
	// Idle cycles after the last expected result before touching registers,
	// generous against the latency of the block.
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 130;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Backpressure knobs, in percent of cycles.
	int idle_pct = 0;
	int stall_pct = 0;
	int mode_index = 0;

	// The stimulus asks for a hold-off by bumping hold_requests; the receiver
	// process owns the countdown.
	int hold_requests = 0;
	int hold_granted = 0;
	int hold_left = 0;

	int quiet = 0;
	int useful = 0;

	// Loose view of the time base and subscription, used only to steer the
	// stimulus toward the interesting states. The checker keeps the exact one.
	logic [31:0] cur_us = '0;
	logic [31:0] cur_s = '0;
	logic [31:0] sub_s = '0;
	logic [31:0] cur_nonce = '0;
	logic [31:0] cfg_timeout = TIMEOUT_RESET;
	logic        sub_view = 1'b0;

	int error_count;
	int pending_results;
	int records_seen;
	int packets_seen;
	int expiries_seen;

	event_count_record_batcher dut (.*);

	ecrb_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.error_count(error_count),
		.pending_results(pending_results),
		.records_seen(records_seen),
		.packets_seen(packets_seen),
		.expiries_seen(expiries_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side. A pending hold-off request takes priority over the random
	// stall pattern and keeps ready low for the whole HOLD_CYCLES hold-off.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_granted != hold_requests) begin
			hold_granted <= hold_requests;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: any accepted request, result or register access counts as
	// progress. A long enough stretch without one means the block is stuck.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
				(psel && penable)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Watchdog expired after %0d quiet cycles", quiet);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Modes: free flowing, sender mostly idle, receiver mostly stalling, both.
	task automatic set_idle_mode(input int m);
		case (m)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 85;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 85;
			end
			default: begin
				idle_pct = 24;
				stall_pct = 24;
			end
		endcase
	endtask

	// Called at a falling edge and returns at a falling edge. Valid is raised
	// once per request and only dropped when the sender takes a gap, so it is
	// never lowered and raised in the same step.
	task automatic send_request(input req_t item);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Builds a request at the current time base and tracks whether the block
	// will act on it. Only subscribes, and events and ticks seen while
	// subscribed, count toward the item total.
	task automatic issue(input logic [1:0] cmd, input logic [7:0] code,
			input logic [31:0] esec, input logic [31:0] etick,
			input logic [31:0] nonce);
		req_t item;
		logic [31:0] held;
		item.command = cmd;
		item.event_code = code;
		item.event_seconds = esec;
		item.event_ticks = etick;
		item.now_microseconds = cur_us;
		item.now_seconds = cur_s;
		item.subscribe_nonce = nonce;
		held = cur_s - sub_s;
		if (cmd == CMD_SUBSCRIBE) begin
			sub_view = 1'b1;
			sub_s = cur_s;
			cur_nonce = nonce;
			useful++;
		end else if (sub_view && cmd != CMD_UNUSED) begin
			useful++;
			if (held > cfg_timeout)
				sub_view = 1'b0;
		end
		send_request(item);
	endtask

	task automatic send_event(input logic [7:0] code);
		issue(CMD_EVENT, code, $urandom, $urandom, $urandom);
	endtask

	task automatic send_tick();
		issue(CMD_TICK, 8'($urandom), $urandom, $urandom, $urandom);
	endtask

	task automatic send_subscribe(input logic [31:0] nonce);
		issue(CMD_SUBSCRIBE, 8'($urandom), $urandom, $urandom, nonce);
	endtask

	// Mostly a handful of hot codes so that counts climb, with the invalid
	// codes at both ends of the range mixed in.
	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 8'd0;
		if (r < 10)
			return 8'd255;
		if (r < 55)
			return 8'($urandom_range(1, 6));
		return 8'($urandom_range(1, 254));
	endfunction

	// Microseconds move in small steps with occasional medium and wild jumps;
	// seconds creep forward but stay inside the subscription window.
	task automatic advance_time();
		int r;
		logic [31:0] held;
		r = $urandom_range(99);
		if (r < 3)
			cur_us = $urandom;
		else if (r < 10)
			cur_us = cur_us + $urandom_range(5000, 40000);
		else
			cur_us = cur_us + $urandom_range(0, 1500);
		held = cur_s - sub_s;
		if ($urandom_range(9) == 0 && held < cfg_timeout)
			cur_s = cur_s + 32'd1;
	endtask

	// Register writes happen with the request channel idle and nothing left
	// in flight. The select stays up between back-to-back writes and drops
	// once at the end.
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({index, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		if (index == REG_TIMEOUT)
			cfg_timeout = value;
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] pause, input logic [31:0] keepalive,
			input logic [31:0] timeout);
		wait_for_drain();
		write_register(REG_PAUSE, pause);
		write_register(REG_KEEPALIVE, keepalive);
		write_register(REG_TIMEOUT, timeout);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Random traffic. While subscribed it is mostly events with ticks in
	// between, so packets fill and close both ways; refreshes, new nonces,
	// the unused command and forced expiries make up the rest. Outside a
	// subscription it mostly resubscribes, with some requests that the block
	// should drop.
	task automatic run_phase(input int count);
		int goal;
		int step;
		int roll;
		goal = useful + count;
		step = 0;
		while (useful < goal) begin
			if (step % 40 == 0) begin
				set_idle_mode(mode_index % 4);
				mode_index++;
			end
			step++;
			advance_time();
			roll = $urandom_range(99);
			if (!sub_view) begin
				if (roll < 75) begin
					if ($urandom_range(4) == 0)
						cur_s = $urandom;
					if ($urandom_range(1) == 0)
						send_subscribe(cur_nonce);
					else
						send_subscribe($urandom);
				end else if (roll < 90) begin
					send_event(pick_code());
				end else begin
					send_tick();
				end
			end else if (roll < 68) begin
				send_event(pick_code());
			end else if (roll < 86) begin
				send_tick();
			end else if (roll < 91) begin
				send_subscribe(cur_nonce);
			end else if (roll < 94) begin
				send_subscribe($urandom);
			end else if (roll < 96) begin
				issue(CMD_UNUSED, pick_code(), $urandom, $urandom, $urandom);
			end else begin
				// Step past the timeout so the next event or tick expires.
				cur_s = sub_s + cfg_timeout + 32'd1 + 32'($urandom_range(0, 3));
				if ($urandom_range(1) == 0)
					send_event(pick_code());
				else
					send_tick();
			end
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, at the reset register values. Nothing is live yet,
		// so an event, a tick and the unused command must all be dropped.
		set_idle_mode(0);
		send_event(8'd5);
		send_tick();
		issue(CMD_UNUSED, 8'd5, $urandom, $urandom, $urandom);
		// A nonce of zero matches the reset nonce and only refreshes.
		send_subscribe(32'd0);
		cur_us = 32'd100;
		// Invalid codes give no record, but the first one still starts the
		// pause timer of the packet.
		send_event(8'd0);
		send_event(8'd255);
		issue(CMD_EVENT, 8'd1, 32'd0, 32'd0, 32'd0);
		issue(CMD_EVENT, 8'd254, '1, '1, '1);
		// Exactly the pause: no partial packet yet. One more microsecond
		// closes it.
		cur_us = 32'd10100;
		send_tick();
		cur_us = 32'd10101;
		send_tick();
		// Keepalive fires at the interval, not one short of it.
		cur_us = 32'd10101 + KEEPALIVE_RESET - 32'd1;
		send_tick();
		cur_us = 32'd10101 + KEEPALIVE_RESET;
		send_tick();
		// A new nonce throws away the records gathered so far.
		send_event(8'd1);
		send_event(8'd2);
		send_subscribe('1);
		cur_us = cur_us + 32'd20000;
		send_tick();
		// At the timeout the subscription holds; one second later it lapses,
		// the event is dropped, and the next one is ignored.
		cur_s = TIMEOUT_RESET;
		send_event(8'd3);
		cur_s = TIMEOUT_RESET + 32'd1;
		send_event(8'd3);
		send_event(8'd3);
		// Resubscribe at the top of the seconds range and let both time
		// bases wrap around.
		cur_s = '1;
		send_subscribe('1);
		cur_s = 32'd0;
		cur_us = '1;
		send_event(8'd7);
		cur_us = 32'd0;
		send_tick();

		// Back the block up: the receiver holds off for a long stretch while
		// the sender keeps offering events, so the result queue fills and
		// the request side has to stall.
		if (!sub_view)
			send_subscribe(cur_nonce);
		hold_requests = hold_requests + 1;
		repeat (70) begin
			cur_us = cur_us + $urandom_range(0, 200);
			send_event(pick_code());
		end

		run_phase(PHASE_ITEMS);
		// Lowest settings: every tick after a move in time closes a partial
		// packet and sends a keepalive, and any change of seconds expires.
		apply_settings('0, '0, '0);
		run_phase(PHASE_ITEMS);
		// Highest settings: only full packets close, and nothing expires.
		apply_settings('1, '1, '1);
		run_phase(PHASE_ITEMS);
		apply_settings(32'd3000, 32'd20000, 32'd5);
		run_phase(PHASE_ITEMS);
		apply_settings($urandom_range(500, 20000), $urandom_range(5000, 100000),
			$urandom_range(1, 20));
		run_phase(PHASE_ITEMS);

		wait_for_drain();
		repeat (20) @(negedge clk);

		$display("Drove %0d requests the block acted on, across five register settings.",
			useful);
		$display("Checked %0d records, %0d packets sent and %0d subscription expiries.",
			records_seen, packets_seen, expiries_seen);
		if (error_count == 0 && pending_results == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
